// ----- rtl/sha1sh_pkg.sv -----
package sha1sh_pkg;

  localparam int unsigned NUM_H = 5;
  localparam int unsigned NUM_W = 16;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_FINISH  = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [6:0] ROUND_STG1 = 7'd20;
  localparam logic [6:0] ROUND_STG2 = 7'd40;
  localparam logic [6:0] ROUND_STG3 = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [5:0] POS_PAD_END    = 6'd56;
  localparam logic [5:0] POS_BLOCK_LAST = 6'd63;
  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [2:0] WORD_IDX_LAST  = 3'd4;

  localparam logic [31:0] H_INIT [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [1:0] {
    STG_CH,
    STG_PAR0,
    STG_MAJ,
    STG_PAR1
  } sha1sh_stage_t;

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } sha1sh_src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } sha1sh_state_t;

  typedef struct packed {
    logic          absorb;
    sha1sh_src_t   src;
    logic          load_work;
    logic          round;
    sha1sh_stage_t stage;
    logic          add;
    logic          restart;
    logic          len_cap;
    logic [2:0]    word_idx;
  } sha1sh_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic cnt_pad_end;
  } sha1sh_sts_t;

  function automatic logic [31:0] round_f(input sha1sh_stage_t stage, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (stage)
      STG_CH:  f = (b & c) | (~b & d);
      STG_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] round_k(input sha1sh_stage_t stage);
    logic [31:0] k;
    unique case (stage)
      STG_CH:   k = 32'h5a827999;
      STG_PAR0: k = 32'h6ed9eba1;
      STG_MAJ:  k = 32'h8f1bbcdc;
      default:  k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/sha1sh_ctrl.sv -----
module sha1sh_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_kind,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_word_index,
  output logic                    out_last,
  input  sha1sh_pkg::sha1sh_sts_t sts,
  output sha1sh_pkg::sha1sh_cmd_t cmd
);
  import sha1sh_pkg::*;

  sha1sh_state_t state_r, state_nxt;
  logic [6:0]    rnd_r, rnd_nxt;
  logic          first_r, first_nxt;
  logic          len_act_r, len_act_nxt;
  logic          ret_pad_r, ret_pad_nxt;
  logic          final_r, final_nxt;
  logic          finished_r, finished_nxt;
  logic [2:0]    idx_r, idx_nxt;

  logic in_take;
  logic take_byte;
  logic take_finish;
  logic take_restart;
  logic is_len;
  logic out_take;

  assign in_take      = in_valid && (state_r == ST_IDLE);
  assign take_restart = in_take && (in_kind == KIND_RESTART);
  assign take_byte    = in_take && (in_kind == KIND_BYTE) && !finished_r;
  assign take_finish  = in_take && (in_kind == KIND_FINISH) && !finished_r;
  // length bytes start once the zero fill reaches the length field
  assign is_len       = !first_r && (len_act_r || sts.cnt_pad_end);
  assign out_take     = (state_r == ST_EMIT) && !out_stall;

  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = 7'd0;
    first_nxt    = first_r;
    len_act_nxt  = len_act_r;
    ret_pad_nxt  = ret_pad_r;
    final_nxt    = final_r;
    finished_nxt = finished_r;
    idx_nxt      = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take_restart) begin
          finished_nxt = 1'b0;
        end else if (take_byte && sts.cnt_last) begin
          state_nxt   = ST_ROUND;
          ret_pad_nxt = 1'b0;
          final_nxt   = 1'b0;
        end else if (take_finish) begin
          state_nxt    = ST_PAD;
          first_nxt    = 1'b1;
          len_act_nxt  = 1'b0;
          finished_nxt = 1'b1;
        end
      end
      ST_PAD: begin
        first_nxt = 1'b0;
        if (is_len) begin
          len_act_nxt = 1'b1;
        end
        if (sts.cnt_last) begin
          state_nxt   = ST_ROUND;
          ret_pad_nxt = 1'b1;
          final_nxt   = is_len;
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (final_r) begin
          state_nxt = ST_EMIT;
          idx_nxt   = 3'd0;
        end else if (ret_pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_take) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == WORD_IDX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.src      = SRC_IN;
    cmd.stage    = STG_CH;
    cmd.word_idx = idx_r;
    in_stall     = (state_r != ST_IDLE);
    out_valid    = (state_r == ST_EMIT);
    unique case (state_r)
      ST_IDLE: begin
        cmd.restart   = take_restart;
        cmd.len_cap   = take_finish;
        cmd.absorb    = take_byte;
        cmd.load_work = take_byte && sts.cnt_last;
      end
      ST_PAD: begin
        cmd.absorb    = 1'b1;
        cmd.load_work = sts.cnt_last;
        if (first_r) begin
          cmd.src = SRC_PAD;
        end else if (is_len) begin
          cmd.src = SRC_LEN;
        end else begin
          cmd.src = SRC_ZERO;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (rnd_r < ROUND_STG1) begin
          cmd.stage = STG_CH;
        end else if (rnd_r < ROUND_STG2) begin
          cmd.stage = STG_PAR0;
        end else if (rnd_r < ROUND_STG3) begin
          cmd.stage = STG_MAJ;
        end else begin
          cmd.stage = STG_PAR1;
        end
      end
      ST_ADD: begin
        cmd.add = 1'b1;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign out_word_index = idx_r;
  assign out_last       = (idx_r == WORD_IDX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rnd_r      <= 7'd0;
      first_r    <= 1'b0;
      len_act_r  <= 1'b0;
      ret_pad_r  <= 1'b0;
      final_r    <= 1'b0;
      finished_r <= 1'b0;
      idx_r      <= 3'd0;
    end else begin
      state_r    <= state_nxt;
      rnd_r      <= rnd_nxt;
      first_r    <= first_nxt;
      len_act_r  <= len_act_nxt;
      ret_pad_r  <= ret_pad_nxt;
      final_r    <= final_nxt;
      finished_r <= finished_nxt;
      idx_r      <= idx_nxt;
    end
  end

endmodule

// ----- rtl/sha1sh_dp.sv -----
module sha1sh_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              in_data_byte,
  input  sha1sh_pkg::sha1sh_cmd_t cmd,
  output sha1sh_pkg::sha1sh_sts_t sts,
  output logic [31:0]             out_digest_word
);
  import sha1sh_pkg::*;

  logic [31:0] blk_r [NUM_W];
  logic [31:0] blk_nxt [NUM_W];
  logic [31:0] h_r [NUM_H];
  logic [31:0] h_nxt [NUM_H];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [5:0]  cnt_r;
  logic [54:0] blocks_r;
  logic [63:0] len_r;

  logic [7:0]  byte_sel;
  logic [31:0] w_new;
  logic [31:0] t_sum;

  always_comb begin
    case (cmd.src)
      SRC_IN:   byte_sel = in_data_byte;
      SRC_PAD:  byte_sel = PAD_BYTE;
      SRC_LEN:  byte_sel = len_r[63:56];
      default:  byte_sel = 8'h00;
    endcase
  end

  // next schedule word, built from the window that holds w[t]..w[t+15]
  always_comb begin
    w_new = blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  assign t_sum = {a_r[26:0], a_r[31:27]} + round_f(cmd.stage, b_r, c_r, d_r) + e_r
               + round_k(cmd.stage) + blk_r[0];

  always_comb begin
    for (int i = 0; i < NUM_W; i++) begin
      blk_nxt[i] = blk_r[i];
    end
    if (cmd.absorb) begin
      // shift the block left one byte, big-endian packing
      for (int i = 0; i < NUM_W - 1; i++) begin
        blk_nxt[i] = {blk_r[i][23:0], blk_r[i+1][31:24]};
      end
      blk_nxt[NUM_W-1] = {blk_r[NUM_W-1][23:0], byte_sel};
    end else if (cmd.round) begin
      for (int i = 0; i < NUM_W - 1; i++) begin
        blk_nxt[i] = blk_r[i+1];
      end
      blk_nxt[NUM_W-1] = w_new;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_H; i++) begin
      h_nxt[i] = h_r[i];
    end
    if (cmd.restart) begin
      for (int i = 0; i < NUM_H; i++) begin
        h_nxt[i] = H_INIT[i];
      end
    end else if (cmd.add) begin
      h_nxt[0] = h_r[0] + a_r;
      h_nxt[1] = h_r[1] + b_r;
      h_nxt[2] = h_r[2] + c_r;
      h_nxt[3] = h_r[3] + d_r;
      h_nxt[4] = h_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_W; i++) begin
      blk_r[i] <= blk_nxt[i];
    end
    if (cmd.load_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (cmd.len_cap) begin
      len_r <= {blocks_r, cnt_r, 3'b000};
    end else if (cmd.absorb && (cmd.src == SRC_LEN)) begin
      len_r <= {len_r[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_H; i++) begin
        h_r[i] <= H_INIT[i];
      end
      cnt_r    <= 6'd0;
      blocks_r <= 55'd0;
    end else begin
      for (int i = 0; i < NUM_H; i++) begin
        h_r[i] <= h_nxt[i];
      end
      if (cmd.restart) begin
        cnt_r    <= 6'd0;
        blocks_r <= 55'd0;
      end else if (cmd.absorb) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == POS_BLOCK_LAST) begin
          blocks_r <= blocks_r + 55'd1;
        end
      end
    end
  end

  assign sts.cnt_last    = (cnt_r == POS_BLOCK_LAST);
  assign sts.cnt_pad_end = (cnt_r == POS_PAD_END);
  assign out_digest_word = h_r[cmd.word_idx];

endmodule

// ----- rtl/sha1_stream_hasher_unit.sv -----
// Byte and restart requests are accepted while idle; the 64th byte of a block starts compression
// (80 rounds on the shared round unit, one chaining add), during which in_stall holds off
// further bytes. A finish walks the padding one byte a cycle, compresses one or two
// blocks, then offers the five digest words one per cycle while out_stall is low, h0 first.
// Synchronous active-low reset loads the initial chaining values and clears the byte
// count, block count and finished flag; the block buffer comes up unknown.
module sha1_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last
);
  import sha1sh_pkg::*;

  sha1sh_cmd_t cmd;
  sha1sh_sts_t sts;

  sha1sh_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_index (out_word_index),
    .out_last       (out_last),
    .sts            (sts),
    .cmd            (cmd)
  );

  sha1sh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_digest_word (out_digest_word)
  );

endmodule
